// File: rtl/servo_pulse_sequencer_macros.svh
// assertion macros used by the servo pulse sequencer rtl
`ifndef SERVO_PULSE_SEQUENCER_MACROS_SVH
`define SERVO_PULSE_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is asserted
`define SPSQ_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("spsq assertion failed");
// next-cycle implication, disabled while reset is asserted
`define SPSQ_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("spsq assertion failed");
`else
`define SPSQ_ASSERT_IMP(name, clk, rstn, ante, cons)
`define SPSQ_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/spsq_pkg.sv
// types and constants of the servo pulse sequencer
`default_nettype none

package spsq_pkg;

    localparam int TICK_W = 16;
    localparam int CH_W   = 2;
    localparam int CNT_W  = 8;
    localparam int IDX_W  = 3;

    localparam logic [TICK_W-1:0] PERIOD_RST   = 16'd40000;
    localparam logic [TICK_W-1:0] MARGIN_RST   = 16'd256;
    localparam logic [TICK_W-1:0] RESERVED_RST = 16'd3000;
    localparam logic [TICK_W-1:0] MIN_W_RST    = 16'd1000;
    localparam logic [TICK_W-1:0] MAX_W_RST    = 16'd5000;
    localparam logic [CH_W-1:0]   PRIMARY_RST  = 2'd0;

    typedef enum logic [IDX_W-1:0] {
        REG_PERIOD   = 3'd0,
        REG_MARGIN   = 3'd1,
        REG_RESERVED = 3'd2,
        REG_MIN_W    = 3'd3,
        REG_MAX_W    = 3'd4,
        REG_PRIMARY  = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_RISE = 2'd0,
        PH_FALL = 2'd1,
        PH_END  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_HIGH = 2'd1,
        ACT_LOW  = 2'd2
    } pin_act_t;

    typedef struct packed {
        logic              mode;
        logic [CH_W-1:0]   channel;
        logic [TICK_W-1:0] width;
    } in_t;

    typedef struct packed {
        logic [TICK_W-1:0] next_event_time;
        logic [CH_W-1:0]   pin_channel;
        logic [1:0]        pin_action;
        logic [TICK_W-1:0] pin_time;
        logic [CNT_W-1:0]  cycle_count;
        logic              width_rejected;
    } res_t;

    typedef struct packed {
        logic [TICK_W-1:0] period;
        logic [TICK_W-1:0] margin;
        logic [TICK_W-1:0] reserved;
        logic [TICK_W-1:0] min_w;
        logic [TICK_W-1:0] max_w;
        logic [CH_W-1:0]   primary;
    } cfg_t;

    // command from the scheduler to the width bank
    typedef struct packed {
        logic              wr_en;
        logic [CH_W-1:0]   wr_chan;
        logic [TICK_W-1:0] wr_width;
        logic              reload;
    } bank_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/spsq_width_bank.sv
// pending and active pulse width registers per channel
`default_nettype none

module spsq_width_bank #(
    parameter int CHANNELS = 4,
    parameter int CIDX_W   = 2
) (
    input  wire logic                       clk,
    input  wire logic                       rstn,
    input  wire spsq_pkg::bank_ctrl_t       ctrl,
    input  wire logic [CIDX_W-1:0]          rd_idx,
    output logic [spsq_pkg::TICK_W-1:0]     rd_width
);
    import spsq_pkg::*;

    logic [TICK_W-1:0] pending_reg [CHANNELS];
    logic [TICK_W-1:0] active_reg  [CHANNELS];
    logic [CIDX_W-1:0] wr_idx;

    assign wr_idx   = CIDX_W'(ctrl.wr_chan);
    assign rd_width = active_reg[rd_idx];

    always_ff @(posedge clk) begin
        if (!rstn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                pending_reg[i] <= '0;
                active_reg[i]  <= '0;
            end
        end else begin
            if (ctrl.wr_en) begin
                pending_reg[wr_idx] <= ctrl.wr_width;
            end
            // reload copies every pending width at once
            if (ctrl.reload) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    active_reg[i] <= pending_reg[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/spsq_sched_core.sv
// three-phase pulse scheduler: phase, channel, timing and reload state
`default_nettype none
`include "servo_pulse_sequencer_macros.svh"

module spsq_sched_core #(
    parameter int CHANNELS = 4,
    parameter int CIDX_W   = 2
) (
    input  wire logic                       clk,
    input  wire logic                       rstn,
    input  wire logic                       fire,
    input  wire spsq_pkg::in_t              item,
    input  wire spsq_pkg::cfg_t             cfg,
    input  wire logic [spsq_pkg::TICK_W-1:0] act_width,
    output logic [CIDX_W-1:0]               rd_idx,
    output spsq_pkg::bank_ctrl_t            bank_ctrl,
    output spsq_pkg::res_t                  res
);
    import spsq_pkg::*;

    localparam int CMP_W = (CIDX_W > CH_W) ? CIDX_W : CH_W;
    localparam logic [CIDX_W-1:0] LAST_CH = CIDX_W'(CHANNELS - 1);

    phase_t            phase_reg, phase_next;
    logic [CIDX_W-1:0] chan_reg, chan_next;
    logic [TICK_W-1:0] start_reg, start_next;
    logic [TICK_W-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]  reload_reg, reload_next;

    logic [TICK_W-1:0] slot_w;
    logic [TICK_W-1:0] shift_m;
    logic [TICK_W-1:0] shift_w;
    logic              is_prim;
    logic              in_range;
    logic              chan_ok;

    assign rd_idx   = chan_reg;
    assign slot_w   = (act_width == '0) ? cfg.reserved : act_width;
    assign shift_m  = shift_reg + cfg.margin;
    assign shift_w  = shift_reg + slot_w;
    assign is_prim  = (CMP_W'(chan_reg) == CMP_W'(cfg.primary));
    assign in_range = (item.width >= cfg.min_w) && (item.width <= cfg.max_w);
    assign chan_ok  = (32'(item.channel) < CHANNELS);

    always_comb begin
        phase_next  = phase_reg;
        chan_next   = chan_reg;
        start_next  = start_reg;
        shift_next  = shift_reg;
        reload_next = reload_reg;
        bank_ctrl   = '0;
        res         = '0;

        if (item.mode) begin
            bank_ctrl.wr_en    = fire && chan_ok;
            bank_ctrl.wr_chan  = item.channel;
            bank_ctrl.wr_width = in_range ? item.width : '0;
            res.pin_channel    = item.channel;
            res.width_rejected = chan_ok && !in_range;
        end else begin
            unique case (phase_reg)
                PH_RISE: begin
                    res.pin_channel = CH_W'(chan_reg);
                    res.pin_time    = shift_m;
                    res.pin_action  = (act_width != '0) ? ACT_HIGH : ACT_NONE;
                    // shift + margin + (width - margin) folds to shift + width
                    shift_next      = is_prim ? shift_m : shift_w;
                    phase_next      = PH_FALL;
                end
                PH_FALL: begin
                    res.pin_channel = CH_W'(chan_reg);
                    shift_next      = is_prim ? shift_w : shift_m;
                    res.pin_time    = shift_next;
                    res.pin_action  = ACT_LOW;
                    if (chan_reg == LAST_CH) begin
                        chan_next  = '0;
                        phase_next = PH_END;
                    end else begin
                        chan_next  = chan_reg + CIDX_W'(1);
                        phase_next = PH_RISE;
                    end
                end
                PH_END: begin
                    bank_ctrl.reload = fire;
                    reload_next      = reload_reg + CNT_W'(1);
                    start_next       = start_reg + cfg.period;
                    shift_next       = start_next - cfg.margin;
                    res.pin_channel  = CH_W'(chan_reg);
                    phase_next       = PH_RISE;
                end
                default: begin
                end
            endcase
        end

        res.next_event_time = shift_next;
        res.cycle_count     = reload_next;
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            phase_reg  <= PH_RISE;
            chan_reg   <= '0;
            start_reg  <= '0;
            shift_reg  <= '0;
            reload_reg <= '0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            chan_reg   <= chan_next;
            start_reg  <= start_next;
            shift_reg  <= shift_next;
            reload_reg <= reload_next;
        end
    end

    `SPSQ_ASSERT_NXT(a_wrap_to_end, clk, rstn, fire && !item.mode && phase_reg == PH_FALL && chan_reg == LAST_CH, phase_reg == PH_END && chan_reg == '0)
    `SPSQ_ASSERT_NXT(a_reload_count, clk, rstn, fire && !item.mode && phase_reg == PH_END, reload_reg == $past(reload_reg) + CNT_W'(1))
    `SPSQ_ASSERT_NXT(a_write_keeps_timing, clk, rstn, fire && item.mode, $stable(shift_reg) && $stable(phase_reg) && $stable(chan_reg))
    `SPSQ_ASSERT_IMP(a_reload_only_at_end, clk, rstn, bank_ctrl.reload, fire && phase_reg == PH_END && !bank_ctrl.wr_en)

endmodule

`default_nettype wire

// File: rtl/servo_pulse_sequencer.sv
// servo pulse sequencer top level: config registers, input and result stages
//
// usage
//  - s_ channel takes one beat per item: mode 1 writes a pending width for
//    a channel, mode 0 reports a compare match and steps the pulse schedule
//    (rise, fall for every channel in turn, then cycle end with width reload)
//  - m_ channel returns exactly one result beat per input beat, in order:
//    next compare time, pin action with its channel and time, reload count
//    and a flag for a width that fell outside min..max and was stored as zero
//  - config port: cfg_we writes cfg_wdata into register cfg_index (period,
//    margin, reserved slot, min width, max width, primary channel); write only
//    while no beat is in flight
//  - an accepted beat is registered in the input stage, and its result is
//    registered in the result stage when that stage is free or draining;
//    throughput one beat per cycle while m_ready stays high, the whole step
//    being one pass of add and select logic between the two stages
//  - reset (aresetn low, synchronous) empties both stages, restores the
//    config defaults and clears phase, channel, times, widths and count
//  - when m_ready stays low the result stage holds its beat and the input
//    stage can still take one more beat before s_ready drops
`default_nettype none

module servo_pulse_sequencer #(
    parameter int CHANNELS = 4
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // input beats
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire spsq_pkg::in_t               s_data,
    // result beats
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output spsq_pkg::res_t                   m_data,
    // config writes
    input  wire logic                        cfg_we,
    input  wire logic [spsq_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [spsq_pkg::TICK_W-1:0] cfg_wdata
);
    import spsq_pkg::*;

    localparam int CIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    cfg_t              cfg_reg;
    in_t               in_reg;
    logic              in_valid_reg, in_valid_next;
    res_t              out_reg;
    logic              out_valid_reg, out_valid_next;

    logic              advance;
    logic [CIDX_W-1:0] rd_idx;
    logic [TICK_W-1:0] act_width;
    bank_ctrl_t        bank_ctrl;
    res_t              step_res;

    // the held item is processed when the result stage is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= step_res;
        end
    end

    // config registers; the primary channel takes the low bits of the write data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.period   <= PERIOD_RST;
            cfg_reg.margin   <= MARGIN_RST;
            cfg_reg.reserved <= RESERVED_RST;
            cfg_reg.min_w    <= MIN_W_RST;
            cfg_reg.max_w    <= MAX_W_RST;
            cfg_reg.primary  <= PRIMARY_RST;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_PERIOD:   cfg_reg.period   <= cfg_wdata;
                REG_MARGIN:   cfg_reg.margin   <= cfg_wdata;
                REG_RESERVED: cfg_reg.reserved <= cfg_wdata;
                REG_MIN_W:    cfg_reg.min_w    <= cfg_wdata;
                REG_MAX_W:    cfg_reg.max_w    <= cfg_wdata;
                REG_PRIMARY:  cfg_reg.primary  <= cfg_wdata[CH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    spsq_sched_core #(
        .CHANNELS (CHANNELS),
        .CIDX_W   (CIDX_W)
    ) u_core (
        .clk       (aclk),
        .rstn      (aresetn),
        .fire      (advance),
        .item      (in_reg),
        .cfg       (cfg_reg),
        .act_width (act_width),
        .rd_idx    (rd_idx),
        .bank_ctrl (bank_ctrl),
        .res       (step_res)
    );

    spsq_width_bank #(
        .CHANNELS (CHANNELS),
        .CIDX_W   (CIDX_W)
    ) u_bank (
        .clk      (aclk),
        .rstn     (aresetn),
        .ctrl     (bank_ctrl),
        .rd_idx   (rd_idx),
        .rd_width (act_width)
    );

endmodule

`default_nettype wire
